[design/lcrf_pkg.sv]
// lcrf_pkg: shared types, offsets and constants for the link controller register file
// used by lcrf_ctrl, lcrf_dp and link_controller_register_file; no dependencies
package lcrf_pkg;

   localparam int STORE_WORDS   = 16384;
   localparam int PHY_REG_COUNT = 16;
   localparam int IDX_W         = $clog2(STORE_WORDS);
   localparam int PHY_IDX_W     = $clog2(PHY_REG_COUNT);

   typedef logic [IDX_W-1:0] widx_type;

   // access kinds
   localparam logic CMD_READ  = 1'b0;
   localparam logic CMD_WRITE = 1'b1;

   // register offsets as byte addresses; their word indexes follow below
   localparam logic [15:0] OFF_NODE_ID   = 16'h8400;
   localparam logic [15:0] OFF_CTRL0     = 16'h8408;
   localparam logic [15:0] OFF_CTRL2     = 16'h8410;
   localparam logic [15:0] OFF_PHY_ACC   = 16'h8414;
   localparam logic [15:0] OFF_INT0      = 16'h8420;
   localparam logic [15:0] OFF_INT0_MASK = 16'h8424;
   localparam logic [15:0] OFF_INT1      = 16'h8428;
   localparam logic [15:0] OFF_INT2      = 16'h8430;
   localparam logic [15:0] OFF_ID_CHECK  = 16'h847c;

   localparam widx_type W_NODE_ID   = OFF_NODE_ID[IDX_W+1:2];
   localparam widx_type W_CTRL0     = OFF_CTRL0[IDX_W+1:2];
   localparam widx_type W_CTRL2     = OFF_CTRL2[IDX_W+1:2];
   localparam widx_type W_PHY_ACC   = OFF_PHY_ACC[IDX_W+1:2];
   localparam widx_type W_INT0      = OFF_INT0[IDX_W+1:2];
   localparam widx_type W_INT0_MASK = OFF_INT0_MASK[IDX_W+1:2];
   localparam widx_type W_INT1      = OFF_INT1[IDX_W+1:2];
   localparam widx_type W_INT2      = OFF_INT2[IDX_W+1:2];
   localparam widx_type W_ID_CHECK  = OFF_ID_CHECK[IDX_W+1:2];

   // fixed words and bit masks
   localparam logic [31:0] NODE_ID_WORD   = 32'hffc00001;
   localparam logic [31:0] ID_CHECK_WORD  = 32'h10000001;
   localparam logic [31:0] PHY_WR_CLR     = 32'h4000ffff;
   localparam logic [31:0] RX_INT_BIT     = 32'h40000000;
   localparam logic [31:0] PHY_RD_BIT     = 32'h80000000;
   localparam logic [31:0] CTRL0_SELF_CLR = 32'h00800000;
   localparam logic [31:0] CTRL2_READY    = 32'h00000008;

   typedef struct packed {
      logic        cmd;
      logic [15:0] addr;
      logic [31:0] wdata;
   } req_type;

   typedef struct packed {
      logic [31:0] rdata;
      logic        irq;
   } rsp_type;

   // controller to datapath
   typedef struct packed {
      logic clear_en;
      logic load;
      logic exec;
   } lcrf_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic clear_done;
   } lcrf_sts_type;

endpackage

[design/lcrf_ctrl.sv]
// lcrf_ctrl: sequencing state machine for the link controller register file
// depends on lcrf_pkg
module lcrf_ctrl import lcrf_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_stall,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output lcrf_cmd_type cmd,
   input  lcrf_sts_type sts
);

   typedef enum logic [1:0] {ST_CLEAR, ST_IDLE, ST_EXEC, ST_RESP} state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_CLEAR: if (sts.clear_done) state_in = ST_IDLE;
         ST_IDLE:  if (req_valid) state_in = ST_EXEC;
         ST_EXEC:  state_in = ST_RESP;
         ST_RESP:  if (!rsp_stall) state_in = ST_IDLE;
         default:  state_in = ST_CLEAR;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_stall    = (state_ff != ST_IDLE);
   assign rsp_valid    = (state_ff == ST_RESP);
   assign cmd.clear_en = (state_ff == ST_CLEAR);
   assign cmd.load     = (state_ff == ST_IDLE) && req_valid;
   assign cmd.exec     = (state_ff == ST_EXEC);

endmodule

[design/lcrf_dp.sv]
// lcrf_dp: word store, interrupt and mask registers, phy registers and response register
// depends on lcrf_pkg; driven by lcrf_ctrl commands
module lcrf_dp import lcrf_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  req_type      req_data,
   output rsp_type      rsp_data,
   input  lcrf_cmd_type cmd,
   output lcrf_sts_type sts
);

   logic [31:0] mem [STORE_WORDS];

   req_type     req_ff;
   logic [31:0] rd_ff;
   rsp_type     rsp_ff, rsp_in;
   logic [31:0] int0_ff, int0_in, mask_ff, mask_in, int1_ff, int1_in, int2_ff, int2_in;
   logic [7:0]  phy_ff [PHY_REG_COUNT];
   widx_type    clr_cnt_ff;

   widx_type             widx;
   logic [31:0]          wd, acc;
   logic                 is_write, phy_wr, phy_rd, rx_irq;
   logic [PHY_IDX_W-1:0] r_rd, r_wr;
   logic                 mem_we;
   widx_type             mem_wa;
   logic [31:0]          mem_wd;

   assign widx     = req_ff.addr[IDX_W+1:2];
   assign wd       = req_ff.wdata;
   assign is_write = (req_ff.cmd == CMD_WRITE);
   assign phy_wr   = wd[30];
   assign phy_rd   = !wd[30] && wd[31];
   assign r_rd     = wd[24 +: PHY_IDX_W];
   assign r_wr     = wd[8 +: PHY_IDX_W];
   assign rx_irq   = is_write && (widx == W_PHY_ACC) && phy_rd && mask_ff[30];

   // phy access word after the mode bits are acted on
   always_comb begin
      if (phy_wr) begin
         acc = wd & ~PHY_WR_CLR;
      end else if (phy_rd) begin
         acc = (wd & ~PHY_RD_BIT) | {20'h0, 4'(r_rd), phy_ff[r_rd]};
      end else begin
         acc = wd;
      end
   end

   always_comb begin
      int0_in = int0_ff;
      mask_in = mask_ff;
      int1_in = int1_ff;
      int2_in = int2_ff;
      mem_we  = 1'b0;
      mem_wa  = widx;
      mem_wd  = wd;
      rsp_in  = rsp_ff;
      if (cmd.clear_en) begin
         mem_we = 1'b1;
         mem_wa = clr_cnt_ff;
         mem_wd = '0;
      end else if (cmd.exec) begin
         rsp_in.rdata = '0;
         rsp_in.irq   = rx_irq;
         if (!is_write) begin
            case (widx)
               W_NODE_ID:   rsp_in.rdata = NODE_ID_WORD;
               W_ID_CHECK:  rsp_in.rdata = ID_CHECK_WORD;
               W_INT0:      rsp_in.rdata = int0_ff;
               W_INT0_MASK: rsp_in.rdata = mask_ff;
               W_INT1:      rsp_in.rdata = int1_ff;
               W_INT2:      rsp_in.rdata = int2_ff;
               default:     rsp_in.rdata = rd_ff;
            endcase
         end else begin
            case (widx)
               W_INT0:      int0_in = int0_ff & ~wd;
               W_INT0_MASK: mask_in = wd;
               W_INT1:      int1_in = int1_ff & ~wd;
               W_INT2:      int2_in = int2_ff & ~wd;
               W_PHY_ACC: begin
                  mem_we = 1'b1;
                  mem_wd = acc;
                  if (rx_irq) int0_in = int0_ff | RX_INT_BIT;
               end
               W_CTRL0: begin
                  mem_we = 1'b1;
                  mem_wd = wd & ~CTRL0_SELF_CLR;
               end
               W_CTRL2: begin
                  mem_we = 1'b1;
                  mem_wd = CTRL2_READY;
               end
               default: mem_we = 1'b1;
            endcase
         end
      end
   end

   // word store, no reset: cleared by the sweep
   always_ff @(posedge clock) begin
      if (mem_we) mem[mem_wa] <= mem_wd;
      if (cmd.load) rd_ff <= mem[req_data.addr[IDX_W+1:2]];
   end

   always_ff @(posedge clock) begin
      if (cmd.load) req_ff <= req_data;
      rsp_ff <= rsp_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         int0_ff    <= '0;
         mask_ff    <= '0;
         int1_ff    <= '0;
         int2_ff    <= '0;
         clr_cnt_ff <= '0;
         for (int i = 0; i < PHY_REG_COUNT; i++) phy_ff[i] <= '0;
      end else begin
         int0_ff <= int0_in;
         mask_ff <= mask_in;
         int1_ff <= int1_in;
         int2_ff <= int2_in;
         if (cmd.clear_en) clr_cnt_ff <= clr_cnt_ff + 1'b1;
         if (cmd.exec && is_write && (widx == W_PHY_ACC) && phy_wr) begin
            phy_ff[r_wr] <= wd[7:0];
         end
      end
   end

   assign sts.clear_done = cmd.clear_en && (clr_cnt_ff == widx_type'(STORE_WORDS - 1));
   assign rsp_data       = rsp_ff;

endmodule

[design/link_controller_register_file.sv]
// link_controller_register_file: top level, one bus access per transaction, one response each
// response: rsp_valid rises in the response state, which follows the execute state after the accept
// one transaction at a time (accept, execute, response handoff); no new request until the response is taken
// reset: a sweep zeroes every word of the word store, req_stall held high meanwhile
// depends on lcrf_pkg, lcrf_ctrl, lcrf_dp
module link_controller_register_file import lcrf_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   // request channel
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   // response channel
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   // command and status between sequencer and datapath
   lcrf_cmd_type cmd;
   lcrf_sts_type sts;

   // sequencer: clearing sweep, then idle / execute / response handshake
   lcrf_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd),
      .sts       (sts)
   );

   // datapath: word store read at accept, update and response formed in the execute cycle
   lcrf_dp u_dp (
      .clock    (clock),
      .reset    (reset),
      .req_data (req_data),
      .rsp_data (rsp_data),
      .cmd      (cmd),
      .sts      (sts)
   );

endmodule
